[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define QS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define QS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/qslerp_pkg.sv]
// ----------------------------------------------------------------------------
// qslerp_pkg
// Types, fixed-point constants and helpers for the quaternion interpolator.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int COMP_WIDTH  = 16;
  localparam int FRAC_BITS   = 14;
  localparam int BLEND_WIDTH = 15;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int NEAR_RESET  = 16;

  // Arc cosine polynomial, coefficients given in Q2.30 and truncated toward zero.
  localparam int ACOS_A0_Q30 = 1686557207;
  localparam int ACOS_A1_Q30 = -227756103;
  localparam int ACOS_A2_Q30 = 79737142;
  localparam int ACOS_A3_Q30 = -20110433;
  localparam int ACOS_A0 = ACOS_A0_Q30 / (1 << (30 - FRAC_BITS));
  localparam int ACOS_A1 = ACOS_A1_Q30 / (1 << (30 - FRAC_BITS));
  localparam int ACOS_A2 = ACOS_A2_Q30 / (1 << (30 - FRAC_BITS));
  localparam int ACOS_A3 = ACOS_A3_Q30 / (1 << (30 - FRAC_BITS));

  // Reciprocals for the sine series divisors 72, 42, 20 and 6. Rounded up
  // with this shift they give the exact floor quotient for 17-bit dividends.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_WIDTH = 23;
  localparam logic [RECIP_WIDTH-1:0] SIN_RECIP [4] = '{
    23'(((1 << RECIP_SHIFT) + 71) / 72),
    23'(((1 << RECIP_SHIFT) + 41) / 42),
    23'(((1 << RECIP_SHIFT) + 19) / 20),
    23'(((1 << RECIP_SHIFT) + 5) / 6)
  };

  localparam int SIN_TERMS  = 4;
  localparam int SQRT_CELLS = 15;
  localparam int DIV_CELLS  = 14;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] left_x;
    logic signed [COMP_WIDTH-1:0] left_y;
    logic signed [COMP_WIDTH-1:0] left_z;
    logic signed [COMP_WIDTH-1:0] left_w;
    logic signed [COMP_WIDTH-1:0] right_x;
    logic signed [COMP_WIDTH-1:0] right_y;
    logic signed [COMP_WIDTH-1:0] right_z;
    logic signed [COMP_WIDTH-1:0] right_w;
    logic [BLEND_WIDTH-1:0]       blend;
  } item_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] out_x;
    logic signed [COMP_WIDTH-1:0] out_y;
    logic signed [COMP_WIDTH-1:0] out_z;
    logic signed [COMP_WIDTH-1:0] out_w;
  } result_t;

  // Square root cell data: radicand bits still to come, remainder, root.
  typedef struct packed {
    logic [29:0] rad;
    logic [16:0] rem;
    logic [14:0] root;
  } sqrt_cell_t;

  // Sine series cell data: argument, its square, partial Horner term.
  typedef struct packed {
    logic [14:0] x;
    logic [15:0] x2;
    logic [14:0] h;
  } sin_cell_t;

  // Divider cell data: partial remainder, divisor, quotient so far.
  typedef struct packed {
    logic [14:0] rem;
    logic [14:0] dsr;
    logic [14:0] quo;
  } div_cell_t;

  // Signed rescale by ONE, truncating toward zero.
  function automatic logic signed [39:0] tdiv(input logic signed [39:0] v);
    if (v < 0) begin
      return (v + 40'(ONE - 1)) >>> FRAC_BITS;
    end
    return v >>> FRAC_BITS;
  endfunction

endpackage

[rtl/qslerp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One registered step of the integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell (
  input  logic                    clk,
  input  logic                    en,
  input  qslerp_pkg::sqrt_cell_t  din,
  output qslerp_pkg::sqrt_cell_t  dout
);
  import qslerp_pkg::*;

  logic [18:0] rem2;
  logic [18:0] trial;

  always_comb begin
    rem2  = {din.rem, din.rad[29:28]};
    trial = {2'b00, din.root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rad <= {din.rad[27:0], 2'b00};
      if (rem2 >= trial) begin
        dout.rem  <= 17'(rem2 - trial);
        dout.root <= {din.root[13:0], 1'b1};
      end else begin
        dout.rem  <= 17'(rem2);
        dout.root <= {din.root[13:0], 1'b0};
      end
    end
  end

endmodule

[rtl/qslerp_div_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One registered restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module qslerp_div_cell (
  input  logic                   clk,
  input  logic                   en,
  input  qslerp_pkg::div_cell_t  din,
  output qslerp_pkg::div_cell_t  dout
);
  import qslerp_pkg::*;

  logic [15:0] r2;

  assign r2 = {din.rem, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.dsr <= din.dsr;
      if (r2 >= {1'b0, din.dsr}) begin
        dout.rem <= 15'(r2 - {1'b0, din.dsr});
        dout.quo <= {din.quo[13:0], 1'b1};
      end else begin
        dout.rem <= r2[14:0];
        dout.quo <= {din.quo[13:0], 1'b0};
      end
    end
  end

endmodule

[rtl/qslerp_sin_cell.sv]
// ----------------------------------------------------------------------------
// qslerp_sin_cell
// One term of the sine series in two stages: h = ONE - x2*h/(k*ONE).
// ----------------------------------------------------------------------------
module qslerp_sin_cell (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [qslerp_pkg::RECIP_WIDTH-1:0]      recip,
  input  qslerp_pkg::sin_cell_t                   din,
  output qslerp_pkg::sin_cell_t                   dout
);
  import qslerp_pkg::*;

  logic [30:0] prod;
  logic [14:0] ax;
  logic [15:0] ax2;
  logic [16:0] aq;
  logic [39:0] qm;
  logic [16:0] d;

  assign prod = din.x2 * din.h;

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= din.x;
      ax2 <= din.x2;
      aq  <= 17'(prod >> FRAC_BITS);
    end
  end

  // The rounded-up reciprocal gives the floor quotient without correction.
  assign qm = aq * recip;
  assign d  = 17'(qm >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      dout.x  <= ax;
      dout.x2 <= ax2;
      dout.h  <= (d > 17'(ONE)) ? 15'd0 : 15'(17'(ONE) - d);
    end
  end

endmodule

[rtl/qslerp_sin.sv]
// ----------------------------------------------------------------------------
// qslerp_sin
// Pipelined sine approximation: square, four series cells, final product.
// ----------------------------------------------------------------------------
module qslerp_sin (
  input  logic        clk,
  input  logic        en,
  input  logic [14:0] arg,
  output logic [14:0] sine
);
  import qslerp_pkg::*;

  sin_cell_t   c [SIN_TERMS+1];
  logic [29:0] sq;
  logic [29:0] fin;

  assign sq  = arg * arg;
  assign fin = c[SIN_TERMS].x * c[SIN_TERMS].h;

  always_ff @(posedge clk) begin
    if (en) begin
      c[0].x  <= arg;
      c[0].x2 <= 16'(sq >> FRAC_BITS);
      c[0].h  <= 15'(ONE);
      sine    <= 15'(fin >> FRAC_BITS);
    end
  end

  for (genvar k = 0; k < SIN_TERMS; k++) begin : g_term
    qslerp_sin_cell u_cell (
      .clk   (clk),
      .en    (en),
      .recip (SIN_RECIP[k]),
      .din   (c[k]),
      .dout  (c[k+1])
    );
  end

endmodule

[rtl/quaternion_slerp.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
// Usage: an item beat on item/item_valid carries two Q2.14 quaternions and a
// Q1.14 blend factor; one result beat per item leaves on result/result_valid.
// Items flow through a row of registered cells (dot product, square root
// cells, arc cosine polynomial, sine series cells, divider cells, weighting)
// and the results leave the row in the order in which their items were accepted.
// Throughput is one item per cycle; the 15 root cells and two chains of 14
// divider cells each take one bit per cycle, so every cell holds its own item.
// When result_stall is high while a result is held, the whole row holds and
// item_stall goes high in the same cycle; otherwise items are taken in every
// cycle, also while earlier ones are still in flight.
// cfg_we writes near_threshold from cfg_data; write it only while idle.
// Reset clears all beat valid flags and sets near_threshold to 16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_slerp (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  qslerp_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output qslerp_pkg::result_t result,
  input  logic                cfg_we,
  input  logic [14:0]         cfg_data
);
  import qslerp_pkg::*;

  localparam int NST      = 48;
  localparam int ST_SQRT  = 3;
  localparam int ST_ROOT  = ST_SQRT + SQRT_CELLS;
  localparam int ST_SIN   = ST_ROOT + 2;
  localparam int ST_SOUT  = ST_SIN + 10;
  localparam int ST_DIV   = ST_SOUT + 1;
  localparam int ST_QUO   = ST_DIV + DIV_CELLS;

  typedef struct packed {
    logic [3:0][15:0] l;
    logic [3:0][16:0] r;
    logic [3:0][31:0] prod;
    logic signed [19:0] c;
    logic [14:0] t;
    logic        slerp;
    logic [14:0] x;
    logic signed [31:0] hm;
    logic signed [16:0] p;
    logic [14:0] om;
    logic [14:0] arg_a;
    logic [14:0] arg_b;
    logic        ovf_a;
    logic        ovf_b;
    logic        so_zero;
    div_cell_t   da;
    div_cell_t   db;
    logic [14:0] alpha;
    logic [14:0] beta;
    logic [3:0][32:0] pa;
    logic [3:0][32:0] pb;
    logic [3:0][15:0] o;
  } side_t;

  logic [14:0] near_threshold;
  logic        en;
  logic [NST:1] vld;
  side_t       pipe [1:NST];
  side_t       nxt  [1:NST];

  sqrt_cell_t  sq  [SQRT_CELLS+1];
  div_cell_t   dva [DIV_CELLS+1];
  div_cell_t   dvb [DIV_CELLS+1];
  logic [14:0] so, sa, sb;

  logic [3:0][15:0] lin;
  logic [3:0][15:0] rin;
  logic signed [19:0] cabs;
  logic signed [20:0] gap;
  logic               neg;
  logic signed [39:0] p0v;
  logic signed [39:0] sum;
  logic signed [39:0] ov;
  logic [29:0] omprod;
  logic [29:0] aprod;
  logic [29:0] bprod;
  logic        qa14, qb14;

  assign en         = !(vld[NST] && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= 15'(NEAR_RESET);
    end else if (cfg_we) begin
      near_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= NST; s++) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  always_comb begin
    lin = {item.left_w, item.left_z, item.left_y, item.left_x};
    rin = {item.right_w, item.right_z, item.right_y, item.right_x};
    for (int s = 2; s <= NST; s++) begin
      nxt[s] = pipe[s-1];
    end

    // Capture and the four dot product terms.
    nxt[1] = pipe[1];
    for (int i = 0; i < 4; i++) begin
      nxt[1].l[i]    = lin[i];
      nxt[1].r[i]    = {rin[i][15], rin[i]};
      nxt[1].prod[i] = 32'($signed(lin[i]) * $signed(rin[i]));
    end
    nxt[1].t = (item.blend > 15'(ONE)) ? 15'(ONE) : item.blend;

    nxt[2].c = 20'(tdiv(40'($signed(pipe[1].prod[0]))) + tdiv(40'($signed(pipe[1].prod[1])))
                 + tdiv(40'($signed(pipe[1].prod[2]))) + tdiv(40'($signed(pipe[1].prod[3]))));

    // Take the shorter path and decide between linear and spherical weights.
    neg  = pipe[2].c < 0;
    cabs = neg ? -pipe[2].c : pipe[2].c;
    gap  = 21'(ONE) - 21'(cabs);
    for (int i = 0; i < 4; i++) begin
      nxt[3].r[i] = neg ? 17'(-$signed(pipe[2].r[i])) : pipe[2].r[i];
    end
    nxt[3].slerp = gap >= $signed({6'b0, near_threshold});
    nxt[3].x     = (cabs > 20'sd16384) ? 15'(ONE) : cabs[14:0];

    // Arc cosine polynomial in Horner form, alongside the root cells.
    nxt[4].hm = 32'(ACOS_A3 * $signed({1'b0, pipe[3].x}));
    nxt[5].p  = 17'(ACOS_A2 + tdiv(40'(pipe[4].hm)));
    nxt[6].hm = 32'(pipe[5].p * $signed({1'b0, pipe[5].x}));
    nxt[7].p  = 17'(ACOS_A1 + tdiv(40'(pipe[6].hm)));
    nxt[8].hm = 32'(pipe[7].p * $signed({1'b0, pipe[7].x}));
    p0v       = ACOS_A0 + tdiv(40'(pipe[8].hm));
    nxt[9].p  = (p0v < 0) ? 17'sd0 : 17'(p0v);

    omprod = sq[SQRT_CELLS].root * pipe[ST_ROOT].p[14:0];
    nxt[ST_ROOT+1].om = 15'(omprod >> FRAC_BITS);

    aprod = (15'(ONE) - pipe[ST_ROOT+1].t) * pipe[ST_ROOT+1].om;
    bprod = pipe[ST_ROOT+1].t * pipe[ST_ROOT+1].om;
    nxt[ST_SIN].arg_a = 15'(aprod >> FRAC_BITS);
    nxt[ST_SIN].arg_b = 15'(bprod >> FRAC_BITS);

    // First quotient bit and overflow check, then the divider cells.
    qa14 = sa >= so;
    qb14 = sb >= so;
    nxt[ST_DIV].so_zero = so == 15'd0;
    nxt[ST_DIV].ovf_a   = {1'b0, sa} >= {so, 1'b0};
    nxt[ST_DIV].ovf_b   = {1'b0, sb} >= {so, 1'b0};
    nxt[ST_DIV].da.rem  = qa14 ? 15'(sa - so) : sa;
    nxt[ST_DIV].da.dsr  = so;
    nxt[ST_DIV].da.quo  = {14'd0, qa14};
    nxt[ST_DIV].db.rem  = qb14 ? 15'(sb - so) : sb;
    nxt[ST_DIV].db.dsr  = so;
    nxt[ST_DIV].db.quo  = {14'd0, qb14};

    if (pipe[ST_QUO].slerp && !pipe[ST_QUO].so_zero) begin
      nxt[ST_QUO+1].alpha = (pipe[ST_QUO].ovf_a || dva[DIV_CELLS].quo > 15'(ONE))
                            ? 15'(ONE) : dva[DIV_CELLS].quo;
      nxt[ST_QUO+1].beta  = (pipe[ST_QUO].ovf_b || dvb[DIV_CELLS].quo > 15'(ONE))
                            ? 15'(ONE) : dvb[DIV_CELLS].quo;
    end else begin
      nxt[ST_QUO+1].alpha = 15'(15'(ONE) - pipe[ST_QUO].t);
      nxt[ST_QUO+1].beta  = pipe[ST_QUO].t;
    end

    for (int i = 0; i < 4; i++) begin
      nxt[ST_QUO+2].pa[i] = 33'($signed({1'b0, pipe[ST_QUO+1].alpha})
                                * $signed(pipe[ST_QUO+1].l[i]));
      nxt[ST_QUO+2].pb[i] = 33'($signed({1'b0, pipe[ST_QUO+1].beta})
                                * $signed(pipe[ST_QUO+1].r[i]));
    end

    // Blend, rescale and saturate each component.
    sum = '0;
    ov  = '0;
    for (int i = 0; i < 4; i++) begin
      sum = 40'($signed(pipe[NST-1].pa[i])) + 40'($signed(pipe[NST-1].pb[i]));
      ov  = tdiv(sum);
      if (ov > 40'sd32767) begin
        nxt[NST].o[i] = 16'h7fff;
      end else if (ov < -40'sd32768) begin
        nxt[NST].o[i] = 16'h8000;
      end else begin
        nxt[NST].o[i] = ov[15:0];
      end
    end
  end

  assign sq[0].rad  = {1'b0, 15'(15'(ONE) - pipe[ST_SQRT].x), 14'd0};
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    qslerp_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq[j]),
      .dout (sq[j+1])
    );
  end

  qslerp_sin u_sin_o (.clk(clk), .en(en), .arg(pipe[ST_SIN].om),    .sine(so));
  qslerp_sin u_sin_a (.clk(clk), .en(en), .arg(pipe[ST_SIN].arg_a), .sine(sa));
  qslerp_sin u_sin_b (.clk(clk), .en(en), .arg(pipe[ST_SIN].arg_b), .sine(sb));

  assign dva[0] = pipe[ST_DIV].da;
  assign dvb[0] = pipe[ST_DIV].db;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    qslerp_div_cell u_cell_a (
      .clk  (clk),
      .en   (en),
      .din  (dva[j]),
      .dout (dva[j+1])
    );
    qslerp_div_cell u_cell_b (
      .clk  (clk),
      .en   (en),
      .din  (dvb[j]),
      .dout (dvb[j+1])
    );
  end

  assign result_valid = vld[NST];
  assign result.out_x = pipe[NST].o[0];
  assign result.out_y = pipe[NST].o[1];
  assign result.out_z = pipe[NST].o[2];
  assign result.out_w = pipe[NST].o[3];

  `QS_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result valid after reset")
  `QS_ASSERT(a_hold_freezes, clk, rst, item_stall |=> $stable(vld), "row moved while held")
  `QS_ASSERT(a_weight_range, clk, rst,
    vld[ST_QUO+1] |-> (pipe[ST_QUO+1].alpha <= 15'(ONE)) && (pipe[ST_QUO+1].beta <= 15'(ONE)),
    "weight above one")

endmodule
